>>> rtl/pixel_replication_upscaler_top_macros.svh
// Assertion macros shared by the RTL of the pixel replication upscaler.
`ifndef PIXEL_REPLICATION_UPSCALER_TOP_MACROS_SVH
`define PIXEL_REPLICATION_UPSCALER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pixel replication upscaler: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pixel replication upscaler: next-cycle check failed");

`endif

>>> rtl/pru_pkg.sv
`default_nettype none

package pru_pkg;

    // Default limits of the row store and of the zoom factor.
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_ZOOM_DEF  = 100;

    // Fixed field widths.
    localparam int ZOOM_W     = 7;
    localparam int DIM_W      = 13;
    localparam int COLOUR_W   = 8;
    localparam int PIXEL_W    = 3 * COLOUR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Depth of the result queue between the two halves.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Input action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // What a result beat carries.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_PAD   = 2'd2
    } t_kind;

    // Classified command from the front half.
    typedef struct packed {
        t_kind kind;
        logic  row_end;
        logic  image_end;
        logic  refused;
    } t_cmd;

    // One finished result beat.
    typedef struct packed {
        t_kind               kind;
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
        logic                row_end;
        logic                image_end;
        logic                refused;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/pixel_replication_upscaler_top.sv
// Integer zoom of a 24-bit image by pixel replication. Each beat pushed is
// either a pixel load or an output tick, and each gives exactly one result
// beat, in order, via the stage register and the result queue. One beat is
// accepted every cycle while the consumer keeps popping; the single-port row
// store sees at most one access per beat (a write for a load, a read for a
// pixel), and a four-deep result queue decouples the two sides, so full
// rises only when four results are queued or in flight. Configuration
// writes clear the row and image counters and are meant for an idle block.
// The row store has no reset; a row is only read back once loaded completely.
`default_nettype none

module pixel_replication_upscaler_top
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_ZOOM  = MAX_ZOOM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_action,
    input  wire logic [COLOUR_W-1:0]   i_in_blue,
    input  wire logic [COLOUR_W-1:0]   i_in_green,
    input  wire logic [COLOUR_W-1:0]   i_in_red,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 o_kind,
    output logic [COLOUR_W-1:0]        o_out_blue,
    output logic [COLOUR_W-1:0]        o_out_green,
    output logic [COLOUR_W-1:0]        o_out_red,
    output logic                       o_row_end,
    output logic                       o_image_end,
    output logic                       o_refused,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic               s1_valid;
    t_cmd               s1_cmd;
    logic [PIXEL_W-1:0] s1_pixel;
    t_result            result;

    // Front half: accepts beats, keeps the counters and the row store.
    pru_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ZOOM  (MAX_ZOOM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_action    (i_action),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_s1_valid  (s1_valid),
        .o_s1_cmd    (s1_cmd),
        .o_s1_pixel  (s1_pixel)
    );

    // Back half: formats results and queues them for the consumer.
    pru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1_cmd   (s1_cmd),
        .i_s1_pixel (s1_pixel),
        .i_pop      (pop),
        .o_full     (full),
        .o_empty    (empty),
        .o_result   (result)
    );

    assign o_kind      = result.kind;
    assign o_out_blue  = result.blue;
    assign o_out_green = result.green;
    assign o_out_red   = result.red;
    assign o_row_end   = result.row_end;
    assign o_image_end = result.image_end;
    assign o_refused   = result.refused;

endmodule

`default_nettype wire

>>> rtl/pru_front.sv
`default_nettype none

module pru_front
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_ZOOM  = MAX_ZOOM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic                  i_full,
    input  wire logic                  i_action,
    input  wire logic [COLOUR_W-1:0]   i_in_blue,
    input  wire logic [COLOUR_W-1:0]   i_in_green,
    input  wire logic [COLOUR_W-1:0]   i_in_red,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_s1_valid,
    output t_cmd                       o_s1_cmd,
    output logic [PIXEL_W-1:0]         o_s1_pixel
);

    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers.
    logic [ZOOM_W-1:0] r_zoom;
    logic [DIM_W-1:0]  r_in_width;
    logic [DIM_W-1:0]  r_in_height;

    // Row and image counters.
    logic [WCW-1:0]    r_load_count, n_load_count;
    logic [WCW-1:0]    r_column,     n_column;
    logic [ZOOM_W-1:0] r_pixel_copy, n_pixel_copy;
    logic [ZOOM_W-1:0] r_row_copy,   n_row_copy;
    logic [1:0]        r_pad_count,  n_pad_count;
    logic [DIM_W-1:0]  r_rows_done,  n_rows_done;

    // Stage register towards the back half.
    logic              r_s1_valid;
    t_cmd              r_s1_cmd, n_cmd;
    logic [PIXEL_W-1:0] r_rd_data;

    // Row store.
    logic [PIXEL_W-1:0] r_row_store [MAX_WIDTH];

    logic              accept;
    logic              cfg_hit;
    logic              mem_we;
    logic              mem_re;
    logic              last;
    logic [ZOOM_W-1:0] eff_zoom;
    logic [WCW-1:0]    eff_width;
    logic [DIM_W-1:0]  eff_height;
    logic [1:0]        pads;
    logic [ZOOM_W:0]   pixel_copy_inc;
    logic [ZOOM_W:0]   row_copy_inc;
    logic [WCW:0]      column_inc;
    logic [2:0]        pad_inc;
    logic [DIM_W:0]    rows_inc;

    assign accept  = i_push && !i_full;
    assign cfg_hit = i_cfg_we && ((i_cfg_idx == REG_ZOOM) || (i_cfg_idx == REG_WIDTH)
                                  || (i_cfg_idx == REG_HEIGHT));

    // Clamp the configuration to the supported range.
    always_comb begin
        if (r_zoom == '0) begin
            eff_zoom = ZOOM_W'(1);
        end else if (int'(r_zoom) > MAX_ZOOM) begin
            eff_zoom = ZOOM_W'(MAX_ZOOM);
        end else begin
            eff_zoom = r_zoom;
        end
        if (r_in_width == '0) begin
            eff_width = WCW'(1);
        end else if (int'(r_in_width) > MAX_WIDTH) begin
            eff_width = WCW'(MAX_WIDTH);
        end else begin
            eff_width = WCW'(r_in_width);
        end
        eff_height = (r_in_height == '0) ? DIM_W'(1) : r_in_height;
    end

    // Padding bytes per output row: (width * zoom) mod 4.
    assign pads = 2'((eff_width[1:0] * eff_zoom[1:0]) & 2'b11);

    assign pixel_copy_inc = {1'b0, r_pixel_copy} + 1'b1;
    assign row_copy_inc   = {1'b0, r_row_copy} + 1'b1;
    assign column_inc     = {1'b0, r_column} + 1'b1;
    assign pad_inc        = {1'b0, r_pad_count} + 1'b1;
    assign rows_inc       = {1'b0, r_rows_done} + 1'b1;

    // Classify the beat and advance the counters.
    always_comb begin
        n_load_count = r_load_count;
        n_column     = r_column;
        n_pixel_copy = r_pixel_copy;
        n_row_copy   = r_row_copy;
        n_pad_count  = r_pad_count;
        n_rows_done  = r_rows_done;
        n_cmd        = '{kind: KIND_NONE, row_end: 1'b0, image_end: 1'b0, refused: 1'b0};
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        last         = 1'b0;

        if (accept) begin
            if (i_action == ACT_LOAD) begin
                if (r_load_count < eff_width) begin
                    mem_we       = 1'b1;
                    n_load_count = WCW'(r_load_count + 1'b1);
                end else begin
                    n_cmd.refused = 1'b1;
                end
            end else if (r_load_count >= eff_width) begin
                if (r_column < eff_width) begin
                    mem_re     = 1'b1;
                    n_cmd.kind = KIND_PIXEL;
                    if (pixel_copy_inc >= {1'b0, eff_zoom}) begin
                        n_pixel_copy = '0;
                        n_column     = column_inc[WCW-1:0];
                        if ((column_inc >= {1'b0, eff_width}) && (pads == 2'd0)) begin
                            last = 1'b1;
                        end
                    end else begin
                        n_pixel_copy = pixel_copy_inc[ZOOM_W-1:0];
                    end
                end else begin
                    n_cmd.kind = KIND_PAD;
                    if (pad_inc >= {1'b0, pads}) begin
                        last = 1'b1;
                    end else begin
                        n_pad_count = pad_inc[1:0];
                    end
                end

                // End of one output row.
                if (last) begin
                    n_cmd.row_end = 1'b1;
                    n_column      = '0;
                    n_pixel_copy  = '0;
                    n_pad_count   = '0;
                    if (row_copy_inc >= {1'b0, eff_zoom}) begin
                        n_row_copy   = '0;
                        n_load_count = '0;
                        if (rows_inc >= {1'b0, eff_height}) begin
                            n_rows_done     = '0;
                            n_cmd.image_end = 1'b1;
                        end else begin
                            n_rows_done = rows_inc[DIM_W-1:0];
                        end
                    end else begin
                        n_row_copy = row_copy_inc[ZOOM_W-1:0];
                    end
                end
            end
        end

        // Any register write discards the row in progress.
        if (cfg_hit) begin
            n_load_count = '0;
            n_column     = '0;
            n_pixel_copy = '0;
            n_row_copy   = '0;
            n_pad_count  = '0;
            n_rows_done  = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom       <= ZOOM_W'(1);
            r_in_width   <= DIM_W'(1);
            r_in_height  <= DIM_W'(1);
            r_load_count <= '0;
            r_column     <= '0;
            r_pixel_copy <= '0;
            r_row_copy   <= '0;
            r_pad_count  <= '0;
            r_rows_done  <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_load_count <= n_load_count;
            r_column     <= n_column;
            r_pixel_copy <= n_pixel_copy;
            r_row_copy   <= n_row_copy;
            r_pad_count  <= n_pad_count;
            r_rows_done  <= n_rows_done;
            r_s1_valid   <= accept;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ZOOM:   r_zoom      <= i_cfg_wdata[ZOOM_W-1:0];
                    REG_WIDTH:  r_in_width  <= i_cfg_wdata[DIM_W-1:0];
                    REG_HEIGHT: r_in_height <= i_cfg_wdata[DIM_W-1:0];
                    default:    r_zoom      <= r_zoom;
                endcase
            end
        end
    end

    // Command payload of the stage register.
    always_ff @(posedge i_clk) begin
        r_s1_cmd <= n_cmd;
    end

    // Row store: at most one access per beat, write for a load, read for a pixel.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_store[r_load_count[AW-1:0]] <= {i_in_red, i_in_green, i_in_blue};
        end
        if (mem_re) begin
            r_rd_data <= r_row_store[r_column[AW-1:0]];
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_cmd   = r_s1_cmd;
    assign o_s1_pixel = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/pru_back.sv
`default_nettype none

`include "pixel_replication_upscaler_top_macros.svh"

module pru_back
    import pru_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s1_valid,
    input  wire t_cmd               i_s1_cmd,
    input  wire logic [PIXEL_W-1:0] i_s1_pixel,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output t_result                 o_result
);

    t_result           r_queue [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count,  n_count;
    logic              pop_ok;
    logic [Q_CW:0]     committed;
    t_result           entry;

    // Build the result beat; colour only travels with a pixel.
    always_comb begin
        entry.kind      = i_s1_cmd.kind;
        entry.row_end   = i_s1_cmd.row_end;
        entry.image_end = i_s1_cmd.image_end;
        entry.refused   = i_s1_cmd.refused;
        if (i_s1_cmd.kind == KIND_PIXEL) begin
            entry.blue  = i_s1_pixel[COLOUR_W-1:0];
            entry.green = i_s1_pixel[2*COLOUR_W-1:COLOUR_W];
            entry.red   = i_s1_pixel[PIXEL_W-1:2*COLOUR_W];
        end else begin
            entry.blue  = '0;
            entry.green = '0;
            entry.red   = '0;
        end
    end

    // Queued entries plus the one in flight must leave room for a new beat.
    assign committed = {1'b0, r_count} + {{Q_CW{1'b0}}, i_s1_valid};
    assign o_full    = committed >= (Q_CW + 1)'(Q_DEPTH);
    assign o_empty   = (r_count == '0);
    assign pop_ok    = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = i_s1_valid ? Q_AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop_ok ? Q_AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (i_s1_valid && !pop_ok) begin
            n_count = Q_CW'(r_count + 1'b1);
        end else if (!i_s1_valid && pop_ok) begin
            n_count = Q_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_s1_valid) begin
            r_queue[r_wr_ptr] <= entry;
        end
    end

    assign o_result = r_queue[r_rd_ptr];

    // The in-flight beat always finds a free slot.
    `PRU_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, 1'b1, committed <= (Q_CW + 1)'(Q_DEPTH))
    // An image ends only on a row end.
    `PRU_ASSERT_NOW(a_image_on_row, i_clk, i_rst_n, !o_empty && o_result.image_end, o_result.row_end)
    // A refused load carries nothing.
    `PRU_ASSERT_NOW(a_refused_none, i_clk, i_rst_n, !o_empty && o_result.refused, o_result.kind == KIND_NONE)
    // A write without a pop grows the queue by one.
    `PRU_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, i_s1_valid && !pop_ok, r_count == Q_CW'($past(r_count) + 1'b1))

endmodule

`default_nettype wire

>>> verif/tb_pixel_replication_upscaler_top.sv
`timescale 1ns / 100ps

module tb_pixel_replication_upscaler_top;
    import pru_pkg::*;

    // Register index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int IDLE_SETTLE    = 8;
    localparam int SINK_HOLD      = 150;
    localparam int CYCLE_LIMIT    = 500000;

    // One row of the directed stimulus table.
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  act;
        logic [COLOUR_W-1:0]   blue;
        logic [COLOUR_W-1:0]   green;
        logic [COLOUR_W-1:0]   red;
        bit                    typed;
        t_result               want;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_action    = ACT_LOAD;
    logic [COLOUR_W-1:0]   i_in_blue   = '0;
    logic [COLOUR_W-1:0]   i_in_green  = '0;
    logic [COLOUR_W-1:0]   i_in_red    = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [1:0]            o_kind;
    logic [COLOUR_W-1:0]   o_out_blue;
    logic [COLOUR_W-1:0]   o_out_green;
    logic [COLOUR_W-1:0]   o_out_red;
    logic                  o_row_end;
    logic                  o_image_end;
    logic                  o_refused;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = REG_ZOOM;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Expected result beats, oldest first.
    t_result pending_units[$];
    int      failures   = 0;
    int      cycle_count = 0;
    bit      send_quiet = 1'b0;
    bit      sink_quiet = 1'b0;
    bit      rx_hold_req = 1'b0;

    // Shadow copy of the upscaler: row store, counters and registers.
    logic [PIXEL_W-1:0]    row_mem [MAX_WIDTH_DEF];
    logic [ZOOM_W-1:0]     zoom_reg   = 7'd1;
    logic [DIM_W-1:0]      width_reg  = 13'd1;
    logic [DIM_W-1:0]      height_reg = 13'd1;
    int                    load_cnt   = 0;
    int                    col        = 0;
    int                    pix_copy   = 0;
    int                    row_copy   = 0;
    int                    pad_cnt    = 0;
    int                    rows_done  = 0;

    pixel_replication_upscaler_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (o_kind),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end),
        .o_refused   (o_refused),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog: a run still going at CYCLE_LIMIT is reported as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_units.size());
            $display("tb_pixel_replication_upscaler_top: FAIL");
            $finish;
        end
    end

    // Width as the block uses it, clamped to the row store.
    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(width_reg);
    endfunction

    // Works out the result beat of one accepted input beat and advances the shadow state.
    function automatic t_result upscale_next_unit(input logic act, input logic [7:0] b,
                                                  input logic [7:0] g, input logic [7:0] r);
        int      w;
        int      z;
        int      h;
        int      pads;
        bit      row_last;
        t_result res;
        w = eff_width();
        z = (zoom_reg == 0) ? 1 : ((zoom_reg > MAX_ZOOM_DEF) ? MAX_ZOOM_DEF : int'(zoom_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        pads = (w * z) & 3;
        row_last = 1'b0;
        res = '0;
        if (act == ACT_LOAD) begin
            if (load_cnt < w) begin
                row_mem[load_cnt] = {r, g, b};
                load_cnt++;
            end else begin
                res.refused = 1'b1;
            end
            return res;
        end
        // A tick before the row is complete yields nothing.
        if (load_cnt < w) return res;
        if (col < w) begin
            res.kind = KIND_PIXEL;
            {res.red, res.green, res.blue} = row_mem[col];
            pix_copy++;
            if (pix_copy >= z) begin
                pix_copy = 0;
                col++;
                if (col >= w && pads == 0) row_last = 1'b1;
            end
        end else begin
            res.kind = KIND_PAD;
            pad_cnt++;
            if (pad_cnt >= pads) row_last = 1'b1;
        end
        // End of one output row; after zoom copies the store empties.
        if (row_last) begin
            res.row_end = 1'b1;
            col = 0;
            pix_copy = 0;
            pad_cnt = 0;
            row_copy++;
            if (row_copy >= z) begin
                row_copy = 0;
                load_cnt = 0;
                rows_done++;
                if (rows_done >= h) begin
                    rows_done = 0;
                    res.image_end = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // A register write clears every counter; the spare index does nothing at all.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ZOOM:   zoom_reg = data[ZOOM_W-1:0];
            REG_WIDTH:  width_reg = data;
            REG_HEIGHT: height_reg = data;
            default:    return;
        endcase
        load_cnt = 0;
        col = 0;
        pix_copy = 0;
        row_copy = 0;
        pad_cnt = 0;
        rows_done = 0;
    endfunction

    function automatic void cmp_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    // Compares one popped beat with the oldest expectation.
    task automatic check_unit(input logic [1:0] kind, input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input logic re, input logic ie,
                              input logic rf);
        t_result want;
        if (pending_units.size() == 0) begin
            $display("%0t: result beat with nothing expected, kind %0h", $time, kind);
            failures++;
        end else begin
            want = pending_units.pop_front();
            cmp_field("kind", want.kind, kind);
            cmp_field("out_blue", want.blue, b);
            cmp_field("out_green", want.green, g);
            cmp_field("out_red", want.red, r);
            cmp_field("row_end", want.row_end, re);
            cmp_field("image_end", want.image_end, ie);
            cmp_field("refused", want.refused, rf);
        end
    endtask

    // Offers one input beat after a random gap and records its expected result.
    task automatic send_unit(input logic act, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r, input bit typed, input t_result typed_res);
        int      gap;
        t_result res;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_action <= act;
        i_in_blue <= b;
        i_in_green <= g;
        i_in_red <= r;
        // Inputs are steady at the falling edge, so full there decides the next rising edge.
        do @(negedge i_clk); while (full);
        res = upscale_next_unit(act, b, g, r);
        pending_units.push_back(typed ? typed_res : res);
        @(posedge i_clk);
    endtask

    // Stops offering beats and waits until every expected beat has come out.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_units.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One setting of the registers, then a stream that mostly fills a row and drains it.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] zoom_val,
                             input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] height_val,
                             input int n_units, input int noise_pct,
                             input bit pause_mid, input bit hold_sink);
        int   k;
        logic act;
        wait_idle();
        write_reg(REG_ZOOM, zoom_val);
        write_reg(REG_WIDTH, width_val);
        write_reg(REG_HEIGHT, height_val);
        if (hold_sink) rx_hold_req = 1'b1;
        for (k = 0; k < n_units; k++) begin
            act = (load_cnt < eff_width()) ? ACT_LOAD : ACT_TICK;
            if ($urandom_range(0, 99) < noise_pct) act = ~act;
            send_unit(act, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            if (pause_mid && k == n_units / 2) wait_idle();
        end
    endtask

    function automatic t_row item_row(input logic act, input logic [7:0] b,
                                      input logic [7:0] g, input logic [7:0] r);
        t_row row;
        row = '{default: '0};
        row.act = act;
        row.blue = b;
        row.green = g;
        row.red = r;
        return row;
    endfunction

    function automatic t_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic t_row typed_row(input logic act, input logic [7:0] b,
                                       input logic [7:0] g, input logic [7:0] r,
                                       input t_kind k, input logic [7:0] wb,
                                       input logic [7:0] wg, input logic [7:0] wr,
                                       input logic re, input logic ie, input logic rf);
        t_row row;
        row = item_row(act, b, g, r);
        row.typed = 1'b1;
        row.want.kind = k;
        row.want.blue = wb;
        row.want.green = wg;
        row.want.red = wr;
        row.want.row_end = re;
        row.want.image_end = ie;
        row.want.refused = rf;
        return row;
    endfunction

    // Result side: pops with random stalls, and once holds off long enough to fill the block.
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(negedge i_clk); while (empty);
            check_unit(o_kind, o_out_blue, o_out_green, o_out_red,
                       o_row_end, o_image_end, o_refused);
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_row              stim_table[$];
        int                i;
        int                p;
        logic [DIM_W-1:0]  z;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;

        // Registers start at zoom 1, width 1, height 1: a one-pixel image whose single
        // row ends in one pad beat.
        stim_table.push_back(typed_row(ACT_TICK, 8'h00, 8'h00, 8'h00,
                                       KIND_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
        stim_table.push_back(typed_row(ACT_LOAD, 8'hFF, 8'h00, 8'hFF,
                                       KIND_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
        stim_table.push_back(typed_row(ACT_LOAD, 8'h00, 8'hFF, 8'h00,
                                       KIND_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
        stim_table.push_back(typed_row(ACT_TICK, 8'h00, 8'h00, 8'h00,
                                       KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0));
        stim_table.push_back(typed_row(ACT_TICK, 8'h00, 8'h00, 8'h00,
                                       KIND_PAD, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
        // Zoom with junk in the upper data bits, width three, height zero acting as one.
        stim_table.push_back(write_row(REG_ZOOM, 13'h1F82));
        stim_table.push_back(write_row(REG_WIDTH, 13'd3));
        stim_table.push_back(write_row(REG_HEIGHT, 13'd0));
        stim_table.push_back(item_row(ACT_LOAD, 8'h12, 8'h34, 8'h56));
        stim_table.push_back(item_row(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF));
        stim_table.push_back(item_row(ACT_LOAD, 8'h00, 8'h00, 8'h00));
        // The spare index must leave the loaded row in place.
        stim_table.push_back(write_row(REG_SPARE, 13'h1FFF));
        for (i = 0; i < 16; i++) stim_table.push_back(item_row(ACT_TICK, 8'h00, 8'h00, 8'h00));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (i = 0; i < stim_table.size(); i++) begin
            if (stim_table[i].is_write) begin
                wait_idle();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_data);
            end else begin
                send_unit(stim_table[i].act, stim_table[i].blue, stim_table[i].green,
                          stim_table[i].red, stim_table[i].typed, stim_table[i].want);
            end
        end

        // Extremes: zoom beyond the limit, zoom at the limit, and a row wider than the store.
        run_phase(13'h007F, 13'd1, 13'h1FFF, 200, 5, 1'b0, 1'b0);
        run_phase(13'd100, 13'd2, 13'd1, 220, 5, 1'b0, 1'b0);
        run_phase(13'd1, 13'h1FFF, 13'd1, 100, 3, 1'b0, 1'b0);

        // Random settings, mostly small so that rows and images complete often.
        for (p = 0; p < 12; p++) begin
            if (p == 0) begin
                z = 13'd0;
                w = 13'd0;
                h = 13'd2;
            end else begin
                z = DIM_W'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 127)
                                                        : $urandom_range(0, 5));
                w = DIM_W'($urandom_range(0, 10));
                h = DIM_W'($urandom_range(0, 3));
            end
            run_phase(z, w, h, 35, 10, p == 3, p == 5);
        end

        wait_idle();
        repeat (IDLE_SETTLE) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb_pixel_replication_upscaler_top: PASS");
        end else begin
            $display("tb_pixel_replication_upscaler_top: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pru_pkg.sv
rtl/pru_front.sv
rtl/pru_back.sv
rtl/pixel_replication_upscaler_top.sv
verif/tb_pixel_replication_upscaler_top.sv
